>>> sv/u8u16_pkg.sv
// shared types, constants and the per-byte step function of the utf-8 to utf-16 converter
package u8u16_pkg;

   localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
   localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
   localparam logic [20:0] SUPPLEMENT_BASE  = 21'h10000;
   localparam logic [15:0] CAPACITY_RESET   = 16'hFFFF;
   localparam int          GROUP_UNITS      = 4;
   localparam int          QUEUE_DEPTH      = 4;

   // results caused by one accepted byte
   typedef struct packed {
      logic [GROUP_UNITS-1:0][15:0] units;
      logic [2:0]                   n;
      logic                         term;
      logic [15:0]                  count;
   } group_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      group_type grp;
   } head_type;

   // outcome of handling one byte with no lead held
   typedef struct packed {
      logic        emit;
      logic        term;
      logic        set_lead;
      logic [15:0] unit;
      logic [15:0] uw;
      logic        stop;
      logic [15:0] count;
   } fresh_type;

   // one byte that starts fresh: ascii, lead, stray or terminator
   function automatic fresh_type fresh_step(input logic [7:0] b, input logic [15:0] uw,
                                            input logic stop, input logic [15:0] limit);
      fresh_type r;
      r          = '0;
      r.uw       = uw;
      r.stop     = stop;
      if (b == 8'h00) begin
         r.emit  = 1'b1;
         r.term  = 1'b1;
         r.count = uw;
         r.uw    = '0;
         r.stop  = 1'b0;
      end else if (stop) begin
         r.stop  = 1'b1;
      end else if (uw >= limit) begin
         r.stop  = 1'b1;
      end else if (b[7] == 1'b0) begin
         r.emit  = 1'b1;
         r.unit  = {8'h00, b};
         r.uw    = uw + 16'd1;
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
         r.set_lead = 1'b1;
      end else begin
         r.emit  = 1'b1;
         r.unit  = REPLACEMENT_UNIT;
         r.uw    = uw + 16'd1;
      end
      return r;
   endfunction

endpackage

>>> sv/u8u16_front.sv
// front end: decodes each byte against the held lead and builds its group of code units
module u8u16_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic [15:0]          limit,
   output logic                 enq,
   output u8u16_pkg::group_type grp
);
   import u8u16_pkg::*;

   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  c0_ff, c0_in;
   logic [7:0]  c1_ff, c1_in;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] uw_ff, uw_in;
   logic        stop_ff, stop_in;

   logic        lead_held;
   logic        is_cont;
   logic [1:0]  need;
   logic [20:0] cp;
   logic [20:0] cp_off;
   logic [2:0]  cnt;
   logic [15:0] cur_uw;
   logic        cur_stop;
   fresh_type   r0, r1, r2;

   assign lead_held = (lead_ff != 8'h00);
   assign is_cont   = (in_byte[7:6] == 2'b10);

   // continuations needed by the held lead
   always_comb begin
      if (lead_ff[7:5] == 3'b110) begin
         need = 2'd1;
      end else if (lead_ff[7:4] == 4'b1110) begin
         need = 2'd2;
      end else begin
         need = 2'd3;
      end
   end

   // code point assembled from the lead, held continuations and this byte
   always_comb begin
      unique case (need)
         2'd1:    cp = {10'd0, lead_ff[4:0], in_byte[5:0]};
         2'd2:    cp = {5'd0, lead_ff[3:0], c0_ff[5:0], in_byte[5:0]};
         default: cp = {lead_ff[2:0], c0_ff[5:0], c1_ff[5:0], in_byte[5:0]};
      endcase
   end

   assign cp_off = cp - SUPPLEMENT_BASE;

   // next state and result group
   always_comb begin
      lead_in  = lead_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      pend_in  = pend_ff;
      uw_in    = uw_ff;
      stop_in  = stop_ff;
      grp      = '0;
      cnt      = '0;
      cur_uw   = uw_ff;
      cur_stop = stop_ff;
      r0       = '0;
      r1       = '0;
      r2       = '0;
      if (!lead_held) begin
         // plain byte
         r0      = fresh_step(in_byte, uw_ff, stop_ff, limit);
         uw_in   = r0.uw;
         stop_in = r0.stop;
         if (r0.emit) begin
            grp.units[0] = r0.unit;
            cnt          = 3'd1;
         end
         if (r0.set_lead) begin
            lead_in = in_byte;
            pend_in = '0;
         end
         if (r0.term) begin
            lead_in = '0;
            c0_in   = '0;
            c1_in   = '0;
            pend_in = '0;
         end
         grp.term  = r0.term;
         grp.count = r0.count;
      end else if (is_cont) begin
         if ({1'b0, pend_ff} + 3'd1 >= {1'b0, need}) begin
            // sequence complete
            lead_in = '0;
            pend_in = '0;
            if (cp[20:16] == 5'd0) begin
               grp.units[0] = cp[15:0];
               cnt          = 3'd1;
               uw_in        = uw_ff + 16'd1;
            end else if ({1'b0, uw_ff} + 17'd1 >= {1'b0, limit}) begin
               stop_in = 1'b1;
            end else begin
               // leads up to f7 reach past 0x10ffff, so the high half keeps 11 bits
               grp.units[0] = HIGH_SURR_BASE + {5'd0, cp_off[20:10]};
               grp.units[1] = LOW_SURR_BASE + {6'd0, cp_off[9:0]};
               cnt          = 3'd2;
               uw_in        = uw_ff + 16'd2;
            end
         end else begin
            // hold the continuation
            if (pend_ff[0] == 1'b0) begin
               c0_in = in_byte;
            end else begin
               c1_in = in_byte;
            end
            pend_in = pend_ff + 2'd1;
         end
      end else begin
         // missing continuation: lead gives a replacement, held bytes replay
         lead_in      = '0;
         pend_in      = '0;
         grp.units[0] = REPLACEMENT_UNIT;
         cnt          = 3'd1;
         cur_uw       = uw_ff + 16'd1;
         if (pend_ff >= 2'd1) begin
            r0       = fresh_step(c0_ff, cur_uw, cur_stop, limit);
            cur_uw   = r0.uw;
            cur_stop = r0.stop;
            if (r0.emit) begin
               grp.units[cnt[1:0]] = r0.unit;
               cnt                 = cnt + 3'd1;
            end
         end
         if (pend_ff >= 2'd2) begin
            r1       = fresh_step(c1_ff, cur_uw, cur_stop, limit);
            cur_uw   = r1.uw;
            cur_stop = r1.stop;
            if (r1.emit) begin
               grp.units[cnt[1:0]] = r1.unit;
               cnt                 = cnt + 3'd1;
            end
         end
         r2      = fresh_step(in_byte, cur_uw, cur_stop, limit);
         uw_in   = r2.uw;
         stop_in = r2.stop;
         if (r2.emit) begin
            grp.units[cnt[1:0]] = r2.unit;
            cnt                 = cnt + 3'd1;
         end
         if (r2.set_lead) begin
            lead_in = in_byte;
         end
         if (r2.term) begin
            c0_in = '0;
            c1_in = '0;
         end
         grp.term  = r2.term;
         grp.count = r2.count;
      end
      grp.n = cnt;
   end

   assign enq = accept && (cnt != 3'd0);

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         c0_ff   <= '0;
         c1_ff   <= '0;
         pend_ff <= '0;
         uw_ff   <= '0;
         stop_ff <= 1'b0;
      end else if (accept) begin
         lead_ff <= lead_in;
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         pend_ff <= pend_in;
         uw_ff   <= uw_in;
         stop_ff <= stop_in;
      end
   end

endmodule

>>> sv/u8u16_queue.sv
// short queue of result groups between front and back end
module u8u16_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enq,
   input  u8u16_pkg::group_type enq_grp,
   input  logic                 deq,
   output logic                 full,
   output u8u16_pkg::head_type  head
);
   import u8u16_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   group_type              entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]         count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.grp   = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (!enq && deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[wr_ptr_ff] <= enq_grp;
      end
   end

endmodule

>>> sv/u8u16_back.sv
// back end: hands out the units of the head group one word at a time
module u8u16_back (
   input  logic                clock,
   input  logic                reset,
   input  u8u16_pkg::head_type head,
   input  logic                pop,
   output logic                deq,
   output logic                empty,
   output logic [15:0]         code_unit,
   output logic                is_terminator,
   output logic [15:0]         unit_count,
   output logic                last
);
   import u8u16_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       take;

   assign empty         = !head.valid;
   assign last          = ({1'b0, idx_ff} == head.grp.n - 3'd1);
   assign code_unit     = head.grp.units[idx_ff];
   assign is_terminator = head.grp.term && last;
   assign unit_count    = is_terminator ? head.grp.count : 16'd0;
   assign take          = pop && head.valid;
   assign deq           = take && last;

   // position within the head group
   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

>>> sv/utf8_to_utf16_converter.sv
// top level of the utf-8 to utf-16 converter
// Usage:
//  Bytes enter on req_in_byte, taken when req_push is high and req_full low.
//  UTF-16 words leave on rsp_*; the oldest is shown while rsp_empty is low
//  and is taken when rsp_pop is high. rsp_last marks the final word caused
//  by one input byte; a zero byte yields a terminator word with
//  rsp_is_terminator set and rsp_unit_count holding the units written.
//  The capacity register is written through csr_valid/csr_ready (always
//  ready); the user must write it only while the block is idle, as this is
//  not enforced. It counts units including the terminator. Throughput: one
//  byte per cycle while each byte gives at most one word and rsp_pop stays
//  high; a byte giving k words (surrogate pair or replayed replacements,
//  k <= 4) holds the result side until all k are popped. A four-entry group
//  queue between the decoder and the word serializer sets how long bursts
//  are absorbed. When the receiver stalls, the queue fills and req_full rises.
//  Reset clears the decoder state and the queue and sets capacity to 65535.
module utf8_to_utf16_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_is_terminator,
   output logic [15:0] rsp_unit_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_capacity_units
);
   import u8u16_pkg::*;

   logic [15:0] limit_ff, limit_in;
   logic        accept;
   logic        enq;
   logic        deq;
   group_type   grp;
   head_type    head;

   // data unit limit kept as capacity minus one, zero capacity acts as one
   assign csr_ready = 1'b1;
   assign limit_in  = (csr_capacity_units == 16'd0) ? 16'd0 : csr_capacity_units - 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CAPACITY_RESET - 16'd1;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= limit_in;
      end
   end

   assign accept = req_push && !req_full;

   u8u16_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .limit   (limit_ff),
      .enq     (enq),
      .grp     (grp)
   );

   u8u16_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .enq     (enq),
      .enq_grp (grp),
      .deq     (deq),
      .full    (req_full),
      .head    (head)
   );

   u8u16_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (rsp_pop),
      .deq           (deq),
      .empty         (rsp_empty),
      .code_unit     (rsp_code_unit),
      .is_terminator (rsp_is_terminator),
      .unit_count    (rsp_unit_count),
      .last          (rsp_last)
   );

endmodule
